// File: hdl/tfn_pkg.sv
// Shared widths, opcodes and pipeline types for the triangle face normal block.
package tfn_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_COUNT);
    localparam int COORD_W      = 16;
    localparam int EDGE_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int MAG_W        = CROSS_W - 1;
    localparam int HALF_W       = (MAG_W + 1) / 2;
    localparam int PART_W       = 2 * HALF_W;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int FRAC_OUT     = 14;
    localparam int QUO_W        = FRAC_OUT + 1;
    localparam int DIVD_W       = MAG_W + FRAC_OUT;
    localparam int DCMP_W       = DIVD_W + 1;
    localparam int OUT_W        = 16;

    localparam logic OP_STORE    = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;

    typedef logic [2:0][COORD_W-1:0] t_vertex;

    // Per-item data that rides alongside the square root.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic                  degen;
    } t_side;

endpackage

// File: hdl/tfn_vstore.sv
// Vertex store: two written-together copies give three read ports per cycle.
module tfn_vstore
    import tfn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_wr,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_vertex           i_wdata,
    input  logic              i_rd,
    input  logic [ADDR_W-1:0] i_idx_a,
    input  logic [ADDR_W-1:0] i_idx_b,
    input  logic [ADDR_W-1:0] i_idx_c,
    output logic              o_vld,
    output t_vertex           o_a,
    output t_vertex           o_b,
    output t_vertex           o_c
);

    t_vertex mem_ab [VERTEX_COUNT];
    t_vertex mem_c  [VERTEX_COUNT];
    logic    r_vld;
    t_vertex r_a, r_b, r_c;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_ab[i_waddr] <= i_wdata;
            mem_c[i_waddr]  <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= mem_ab[i_idx_a];
            r_b <= mem_ab[i_idx_b];
            r_c <= mem_c[i_idx_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_rd;
        end
    end

    assign o_vld = r_vld;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_c   = r_c;

endmodule

// File: hdl/tfn_cross.sv
// Edges, cross product, magnitudes and squared length over seven stages.
module tfn_cross
    import tfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_vertex          i_a,
    input  t_vertex          i_b,
    input  t_vertex          i_c,
    output logic             o_vld,
    output logic [SUM_W-1:0] o_sum,
    output t_side            o_side
);

    logic [6:0] r_v;
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [PROD_W-1:0]  r_p  [6];
    logic signed [CROSS_W-1:0] r_n  [3];
    t_side                     r_s4, r_s5, r_s6, r_s7;
    logic [PART_W-1:0]         r_hh [3];
    logic [PART_W-1:0]         r_hl [3];
    logic [PART_W-1:0]         r_ll [3];
    logic [SQ_W-1:0]           r_sq [3];
    logic [SUM_W-1:0]          r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= $signed({i_b[i][COORD_W-1], i_b[i]})
                         - $signed({i_a[i][COORD_W-1], i_a[i]});
                r_e2[i] <= $signed({i_c[i][COORD_W-1], i_c[i]})
                         - $signed({i_a[i][COORD_W-1], i_a[i]});
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= $signed({r_p[2*i][PROD_W-1], r_p[2*i]})
                        - $signed({r_p[2*i+1][PROD_W-1], r_p[2*i+1]});
            end
            for (int i = 0; i < 3; i++) begin
                r_s4.neg[i] <= r_n[i][CROSS_W-1];
                r_s4.mag[i] <= r_n[i][CROSS_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
            end
            r_s4.degen <= 1'b0;
            // split each magnitude in halves for narrow squaring
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= r_s4.mag[i][MAG_W-1:HALF_W] * r_s4.mag[i][MAG_W-1:HALF_W];
                r_hl[i] <= r_s4.mag[i][MAG_W-1:HALF_W] * r_s4.mag[i][HALF_W-1:0];
                r_ll[i] <= r_s4.mag[i][HALF_W-1:0] * r_s4.mag[i][HALF_W-1:0];
            end
            r_s5.neg   <= r_s4.neg;
            r_s5.mag   <= r_s4.mag;
            r_s5.degen <= (r_s4.mag == '0);
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (SQ_W'(r_hh[i]) << (2 * HALF_W))
                         + (SQ_W'(r_hl[i]) << (HALF_W + 1))
                         + SQ_W'(r_ll[i]);
            end
            r_s6  <= r_s5;
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_s7  <= r_s6;
        end
    end

    assign o_vld  = r_v[6];
    assign o_sum  = r_sum;
    assign o_side = r_s7;

endmodule

// File: hdl/tfn_isqrt.sv
// Floor square root, one result bit per pipeline stage.
module tfn_isqrt
    import tfn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [SUM_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              w_vld  [ROOT_W];
    logic [REM_W-1:0]  w_rem  [ROOT_W];
    logic [ROOT_W-1:0] w_root [ROOT_W];
    logic [SUM_W-1:0]  w_rad  [ROOT_W];
    t_side             w_side [ROOT_W];
    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_rad  [ROOT_W];
    t_side             r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0] shifted, trial;
        logic             ge;

        if (g == 0) begin : g_first
            assign w_vld[g]  = i_vld;
            assign w_rem[g]  = '0;
            assign w_root[g] = '0;
            assign w_rad[g]  = i_rad;
            assign w_side[g] = i_side;
        end else begin : g_next
            assign w_vld[g]  = r_vld[g-1];
            assign w_rem[g]  = r_rem[g-1];
            assign w_root[g] = r_root[g-1];
            assign w_rad[g]  = r_rad[g-1];
            assign w_side[g] = r_side[g-1];
        end

        assign shifted = {w_rem[g][REM_W-3:0], w_rad[g][SUM_W-1 -: 2]};
        assign trial   = REM_W'({w_root[g], 2'b01});
        assign ge      = (shifted >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? shifted - trial : shifted;
                r_root[g] <= {w_root[g][ROOT_W-2:0], ge};
                r_rad[g]  <= w_rad[g] << 2;
                r_side[g] <= w_side[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld[g];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

// File: hdl/tfn_div.sv
// Three-lane restoring divider, one quotient bit per stage; the sign bits ride alongside.
module tfn_div
    import tfn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [ROOT_W-1:0]     i_len,
    input  t_side                 i_side,
    output logic                  o_vld,
    output logic [2:0][QUO_W-1:0] o_quo,
    output t_side                 o_side
);

    logic                   w_vld [QUO_W];
    logic [2:0][DIVD_W-1:0] w_rem [QUO_W];
    logic [2:0][QUO_W-1:0]  w_quo [QUO_W];
    logic [ROOT_W-1:0]      w_len [QUO_W];
    t_side                  w_side[QUO_W];
    logic                   r_vld [QUO_W];
    logic [2:0][DIVD_W-1:0] r_rem [QUO_W];
    logic [2:0][QUO_W-1:0]  r_quo [QUO_W];
    logic [ROOT_W-1:0]      r_len [QUO_W];
    t_side                  r_side[QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [DCMP_W-1:0] dsh;

        if (g == 0) begin : g_first
            assign w_vld[g]  = i_vld;
            assign w_quo[g]  = '0;
            assign w_len[g]  = i_len;
            assign w_side[g] = i_side;
            for (genvar l = 0; l < 3; l++) begin : g_init
                assign w_rem[g][l] = DIVD_W'(i_side.mag[l]) << FRAC_OUT;
            end
        end else begin : g_next
            assign w_vld[g]  = r_vld[g-1];
            assign w_rem[g]  = r_rem[g-1];
            assign w_quo[g]  = r_quo[g-1];
            assign w_len[g]  = r_len[g-1];
            assign w_side[g] = r_side[g-1];
        end

        assign dsh = DCMP_W'(w_len[g]) << (QUO_W - 1 - g);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if ({1'b0, w_rem[g][l]} >= dsh) begin
                        r_rem[g][l] <= w_rem[g][l] - dsh[DIVD_W-1:0];
                        r_quo[g][l] <= {w_quo[g][l][QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem[g][l] <= w_rem[g][l];
                        r_quo[g][l] <= {w_quo[g][l][QUO_W-2:0], 1'b0};
                    end
                end
                r_len[g]  <= w_len[g];
                r_side[g] <= w_side[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld[g];
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

// File: hdl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// A triangle transaction passes the store read, the cross product and squared
// length, the square root, the divide and the output register, in that order.
// Throughput: one transaction per cycle when not stalled; all stages move together.
// Reset clears every valid bit; the vertex store is undefined until written.
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [ADDR_W-1:0]         i_vertex_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [ADDR_W-1:0]         i_index_a,
    input  logic [ADDR_W-1:0]         i_index_b,
    input  logic [ADDR_W-1:0]         i_index_c,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [OUT_W-1:0]   o_normal_x,
    output logic signed [OUT_W-1:0]   o_normal_y,
    output logic signed [OUT_W-1:0]   o_normal_z,
    output logic                      o_degenerate
);

    logic                  en, accept;
    logic                  rd_vld, cx_vld, sq_vld, dv_vld;
    t_vertex               va, vb, vc;
    logic [SUM_W-1:0]      sum;
    t_side                 cx_side, sq_side, dv_side;
    logic [ROOT_W-1:0]     len;
    logic [2:0][QUO_W-1:0] quo;
    logic                  r_o_valid, r_degen;
    logic [2:0][OUT_W-1:0] r_norm;

    // Advance everything unless a finished result is held by the consumer.
    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // Store transactions write at acceptance and triangles read at acceptance,
    // so a store is visible to the very next triangle.
    tfn_vstore u_vstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_wr    (accept && (i_opcode == OP_STORE)),
        .i_waddr (i_vertex_index),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_rd    (accept && (i_opcode == OP_TRIANGLE)),
        .i_idx_a (i_index_a),
        .i_idx_b (i_index_b),
        .i_idx_c (i_index_c),
        .o_vld   (rd_vld),
        .o_a     (va),
        .o_b     (vb),
        .o_c     (vc)
    );

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (rd_vld),
        .i_a     (va),
        .i_b     (vb),
        .i_c     (vc),
        .o_vld   (cx_vld),
        .o_sum   (sum),
        .o_side  (cx_side)
    );

    tfn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (cx_vld),
        .i_rad   (sum),
        .i_side  (cx_side),
        .o_vld   (sq_vld),
        .o_root  (len),
        .o_side  (sq_side)
    );

    // |n_i| never exceeds the length, so each quotient fits in 15 bits.
    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_len   (len),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_quo   (quo),
        .o_side  (dv_side)
    );

    // Output register: apply the sign, force zeros on a zero cross product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                if (dv_side.degen) begin
                    r_norm[l] <= '0;
                end else if (dv_side.neg[l]) begin
                    r_norm[l] <= -OUT_W'(quo[l]);
                end else begin
                    r_norm[l] <= OUT_W'(quo[l]);
                end
            end
            r_degen <= dv_side.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_vld;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_normal_x   = r_norm[0];
    assign o_normal_y   = r_norm[1];
    assign o_normal_z   = r_norm[2];
    assign o_degenerate = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == 0 && o_normal_y == 0 && o_normal_z == 0)
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= 16384 && o_normal_x >= -16384
                 && o_normal_y <= 16384 && o_normal_y >= -16384
                 && o_normal_z <= 16384 && o_normal_z >= -16384)
        else $error("normal component out of unit range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 100ps

module tb
    import tfn_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;
    localparam int HOLD_CYCLES = 300;

    // One queued input transaction plus the idling pattern that goes with it.
    typedef struct {
        logic                      opcode;
        logic [ADDR_W-1:0]         vidx;
        logic signed [COORD_W-1:0] cx, cy, cz;
        logic [ADDR_W-1:0]         ia, ib, ic;
        int                        idle_pct;
        int                        stall_pct;
        bit                        drain_first;
        bit                        hold_rx;
    } t_txn;

    typedef struct {
        logic signed [OUT_W-1:0] nx, ny, nz;
        logic                    degen;
    } t_normal;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_opcode;
    logic [ADDR_W-1:0]         i_vertex_index;
    logic signed [COORD_W-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic [ADDR_W-1:0]         i_index_a, i_index_b, i_index_c;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [OUT_W-1:0]   o_normal_x, o_normal_y, o_normal_z;
    logic                      o_degenerate;

    triangle_face_normal uut (.*);

    t_txn    pending_q[$];
    t_normal normal_q[$];
    t_vertex vertex_mem[VERTEX_COUNT];
    bit      gen_written[VERTEX_COUNT];
    int      gen_slots[$];

    int  cur_stall;
    bit  hold_req;
    int  hold_left;
    bit  in_taken;
    int  cycles;
    int  errors, n_stores, n_tris, n_results, n_degen;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Exact cross product, floor root of its squared length, truncating divide.
    function automatic t_normal face_normal(t_vertex a, t_vertex b, t_vertex c);
        longint   e1[3], e2[3], n[3];
        bit [79:0] sumsq, m, cand, root;
        bit [63:0] q;
        t_normal  r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'($signed(b[i])) - longint'($signed(a[i]));
            e2[i] = longint'($signed(c[i])) - longint'($signed(a[i]));
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            m = (n[i] < 0) ? 80'(-n[i]) : 80'(n[i]);
            sumsq += m * m;
        end
        r = '{default: '0};
        if (sumsq == 0) begin
            r.degen = 1'b1;
            return r;
        end
        root = '0;
        for (int bt = 39; bt >= 0; bt--) begin
            cand = root | (80'd1 << bt);
            if (cand * cand <= sumsq) root = cand;
        end
        for (int i = 0; i < 3; i++) begin
            m = (n[i] < 0) ? 80'(-n[i]) : 80'(n[i]);
            q = 64'((m << FRAC_OUT) / root);
            if (n[i] < 0) q = -q;
            if (i == 0) r.nx = q[OUT_W-1:0];
            else if (i == 1) r.ny = q[OUT_W-1:0];
            else r.nz = q[OUT_W-1:0];
        end
        return r;
    endfunction

    task automatic queue_store(int slot, int x, int y, int z, int idle, int stall);
        t_txn t;
        t = '{opcode: OP_STORE, vidx: ADDR_W'(slot),
              cx: COORD_W'(x), cy: COORD_W'(y), cz: COORD_W'(z),
              ia: ADDR_W'($urandom), ib: ADDR_W'($urandom), ic: ADDR_W'($urandom),
              idle_pct: idle, stall_pct: stall, drain_first: 1'b0, hold_rx: 1'b0};
        if (!gen_written[slot]) gen_slots.push_back(slot);
        gen_written[slot] = 1'b1;
        pending_q.push_back(t);
    endtask

    task automatic queue_tri(int a, int b, int c, int idle, int stall);
        t_txn t;
        t = '{opcode: OP_TRIANGLE, vidx: ADDR_W'($urandom),
              cx: COORD_W'($urandom), cy: COORD_W'($urandom), cz: COORD_W'($urandom),
              ia: ADDR_W'(a), ib: ADDR_W'(b), ic: ADDR_W'(c),
              idle_pct: idle, stall_pct: stall, drain_first: 1'b0, hold_rx: 1'b0};
        pending_q.push_back(t);
    endtask

    function automatic int pick_coord();
        int edges[5] = '{-32768, 32767, 0, -1, 1};
        if ($urandom_range(99) < 20) return edges[$urandom_range(4)];
        return $signed(16'($urandom));
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Build the stimulus: directed corners first, then random phases.
    initial begin
        int idle_tab[4]  = '{0, 66, 0, 12};
        int stall_tab[4] = '{0, 0, 66, 12};
        int first;
        // extremes and axis-aligned corners
        queue_store(0, 0, 0, 0, 0, 0);
        queue_store(1023, 32767, 32767, 32767, 0, 0);
        queue_store(1, -32768, -32768, -32768, 0, 0);
        queue_store(2, 256, 0, 0, 0, 0);
        queue_store(3, 0, 256, 0, 0, 0);
        queue_store(512, -32768, 32767, -32768, 0, 0);
        queue_store(341, 32767, -32768, 0, 0, 0);
        queue_store(682, -1, 1, -32768, 0, 0);
        queue_tri(0, 2, 3, 0, 0);          // +z unit normal
        queue_tri(0, 3, 2, 0, 0);          // -z unit normal
        queue_tri(2, 3, 0, 0, 0);
        queue_tri(0, 0, 0, 0, 0);          // all corners coincide
        queue_tri(0, 1023, 1, 0, 0);       // collinear corners
        queue_tri(1023, 1, 512, 0, 0);     // widest edges
        queue_tri(1, 1023, 512, 0, 0);
        queue_tri(341, 682, 1023, 0, 0);
        queue_tri(512, 341, 1, 0, 0);
        queue_tri(2, 2, 3, 0, 0);          // two corners coincide
        queue_store(2, 32767, 32767, -32768, 0, 0); // overwrite a slot
        queue_tri(0, 2, 3, 0, 0);
        // random phases, each opened by a full drain
        for (int ph = 0; ph < 4; ph++) begin
            first = pending_q.size();
            for (int k = 0; k < 345; k++) begin
                if (gen_slots.size() < 3 || $urandom_range(99) < 40)
                    queue_store($urandom_range(1023), pick_coord(), pick_coord(),
                                pick_coord(), idle_tab[ph], stall_tab[ph]);
                else
                    queue_tri(gen_slots[$urandom_range(gen_slots.size() - 1)],
                              gen_slots[$urandom_range(gen_slots.size() - 1)],
                              gen_slots[$urandom_range(gen_slots.size() - 1)],
                              idle_tab[ph], stall_tab[ph]);
            end
            pending_q[first].drain_first = 1'b1;
            if (ph == 0) pending_q[first + 100].hold_rx = 1'b1;
        end
    end

    // Driver: offer the next transaction at the falling edge once the last one went in.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pending_q[0].drain_first
                         && (normal_q.size() != 0 || hold_left != 0)) begin
                i_valid <= 1'b0;   // hold off until every normal is back
            end else if ($urandom_range(99) < pending_q[0].idle_pct) begin
                i_valid <= 1'b0;
            end else begin
                t_txn t;
                t = pending_q.pop_front();
                cur_stall = t.stall_pct;
                if (t.hold_rx) hold_req = 1'b1;
                i_valid        <= 1'b1;
                i_opcode       <= t.opcode;
                i_vertex_index <= t.vidx;
                i_coord_x      <= t.cx;
                i_coord_y      <= t.cy;
                i_coord_z      <= t.cz;
                i_index_a      <= t.ia;
                i_index_b      <= t.ib;
                i_index_c      <= t.ic;
            end
        end
    end

    // Receiver stall, with one long hold-off so the pipeline backs up.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < cur_stall);
        end
    end

    // Monitor: predict on accepted inputs, check accepted results.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_opcode == OP_STORE) begin
                vertex_mem[i_vertex_index] = {i_coord_z, i_coord_y, i_coord_x};
                n_stores++;
            end else begin
                normal_q.push_back(face_normal(vertex_mem[i_index_a],
                                               vertex_mem[i_index_b],
                                               vertex_mem[i_index_c]));
                n_tris++;
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            t_normal e;
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected normal (%0d %0d %0d degen %0b)", $time,
                         o_normal_x, o_normal_y, o_normal_z, o_degenerate);
                errors++;
            end else begin
                e = normal_q.pop_front();
                n_results++;
                if (e.degen) n_degen++;
                check_field("normal_x", e.nx, o_normal_x);
                check_field("normal_y", e.ny, o_normal_y);
                check_field("normal_z", e.nz, o_normal_z);
                check_field("degenerate", e.degen, o_degenerate);
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d normals outstanding", $time, normal_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Reset, then wait for the stimulus and every result to drain.
    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_opcode = OP_STORE;
        i_vertex_index = '0; i_coord_x = '0; i_coord_y = '0; i_coord_z = '0;
        i_index_a = '0; i_index_b = '0; i_index_c = '0;
        cur_stall = 0; hold_req = 0; hold_left = 0; in_taken = 0;
        cycles = 0; errors = 0; n_stores = 0; n_tris = 0; n_results = 0; n_degen = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (i_valid && !in_taken) @(posedge i_clk);
        wait (normal_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d vertex stores and %0d triangles, %0d normals checked",
                 n_stores, n_tris, n_results);
        $display("(%0d degenerate), over four idling phases and one long back-pressure hold",
                 n_degen);
        if (errors == 0 && normal_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/tfn_pkg.sv
hdl/tfn_vstore.sv
hdl/tfn_cross.sv
hdl/tfn_isqrt.sv
hdl/tfn_div.sv
hdl/triangle_face_normal.sv
tb/sv/tb.sv
